### rtl/blirs_pkg.sv
// Shared types and constants for the bounded list block.
package blirs_pkg;

  localparam int unsigned Entries = 32;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW    = $clog2(Entries + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SLICE  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_WR,
    S_REM_RD,
    S_REM_CMP,
    S_REM_FIN,
    S_SL_RD,
    S_SL_CAND,
    S_SL_JRD,
    S_SL_JCMP,
    S_SL_EMIT,
    S_SL_NEXT,
    S_SL_FIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic [5:0]         first_index;
    logic [6:0]         end_index;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] item_value;
    logic               item_valid;
    logic [6:0]         count;
    logic               last;
  } out_t;

endpackage

### rtl/bounded_list_insert_remove_slice.sv
// Bounded ordered list: insert, remove-all-equal and slice read, one shared comparator.
//
// Input words arrive on in_valid_i/in_ready_o carrying cmd, value and the slice
// bounds; results leave on out_valid_o/out_ready_i. Insert and remove give one
// result word, a slice gives one word per emitted element with last set on the
// final one. The list lives in a single-port-read memory; one equality compare
// per cycle is made by a shared comparator under the sequencer, so one input
// word is handled at a time and in_ready_o is high only while idle.
// Work per command (n = entries held, L = slice length):
//   insert: one write, after a scan of up to n entries with the duplicate check active
//   remove: a read and compare of all n entries, with in-place compaction
//   slice : a read of each of the L elements, plus compares against earlier slice
//           elements when duplicates are disallowed (quadratic in L)
// Each memory read is registered; a compare state then uses the registered data.
// A finished result sits in an output register, so the sequencer runs on
// while it waits; it only pauses when it must push a second word and the
// receiver has not taken the first. Reset empties the list (count 0), sets
// allow_duplicates to 1 and drops any pending result; memory contents stay
// undefined but are never read past the count. The user must write allow_duplicates
// by cfg_we_i/cfg_wdata_i only while idle; the block does not enforce this.
module bounded_list_insert_remove_slice
  import blirs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  state_e             state_q, state_d;
  logic               allow_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    jdx_q, jdx_d;
  logic [CntW-1:0]    wr_q, wr_d;
  logic [CntW-1:0]    first_q, first_d;
  logic [CntW-1:0]    end_q, end_d;
  logic               found_q, found_d;
  logic               pend_q, pend_d;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] cand_q, cand_d;
  logic signed [31:0] pend_val_q, pend_val_d;
  status_e            status_q, status_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic signed [31:0] mem [Entries];
  logic signed [31:0] rdata_q;
  logic [AddrW-1:0]   mem_raddr, mem_waddr;
  logic               mem_we;
  logic signed [31:0] mem_wdata;

  logic               push;
  out_t               push_data;
  logic               out_free;
  logic               accept;
  logic               eq;
  logic               full;
  logic               slice_empty;
  logic [6:0]         cnt7, first7, end_clip7;
  logic [CntW-1:0]    idx_inc, jdx_inc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt7        = 7'(count_q);
  assign first7      = {1'b0, in_data_i.first_index};
  assign end_clip7   = (in_data_i.end_index > cnt7) ? cnt7 : in_data_i.end_index;
  assign full        = (count_q == CntW'(Entries));
  assign slice_empty = (first7 >= cnt7) || (end_clip7 <= first7);
  assign idx_inc     = idx_q + CntW'(1);
  assign jdx_inc     = jdx_q + CntW'(1);

  // shared comparator: candidate check in the slice dedup loop, else the command value
  assign eq = (rdata_q == ((state_q == S_SL_JCMP) ? cand_q : val_q));

  assign mem_raddr = (state_q == S_SL_JRD) ? jdx_q[AddrW-1:0] : idx_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd == CMD_INSERT) begin
            if (full) state_d = S_RESP;
            else if (allow_q || count_q == '0) state_d = S_INS_WR;
            else state_d = S_SCAN_RD;
          end else if (in_data_i.cmd == CMD_REMOVE) begin
            state_d = (count_q == '0) ? S_RESP : S_REM_RD;
          end else if (in_data_i.cmd == CMD_SLICE) begin
            state_d = slice_empty ? S_RESP : S_SL_RD;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN_RD:  state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (eq) state_d = S_RESP;
        else if (idx_inc == count_q) state_d = S_INS_WR;
        else state_d = S_SCAN_RD;
      end
      S_INS_WR:   state_d = S_RESP;
      S_REM_RD:   state_d = S_REM_CMP;
      S_REM_CMP:  state_d = (idx_inc == count_q) ? S_REM_FIN : S_REM_RD;
      S_REM_FIN:  state_d = S_RESP;
      S_SL_RD:    state_d = S_SL_CAND;
      S_SL_CAND:  state_d = (allow_q || idx_q == first_q) ? S_SL_EMIT : S_SL_JRD;
      S_SL_JRD:   state_d = S_SL_JCMP;
      S_SL_JCMP: begin
        if (eq) state_d = S_SL_NEXT;
        else if (jdx_inc == idx_q) state_d = S_SL_EMIT;
        else state_d = S_SL_JRD;
      end
      S_SL_EMIT:  state_d = (!pend_q || out_free) ? S_SL_NEXT : S_SL_EMIT;
      S_SL_NEXT:  state_d = (idx_inc == end_q) ? S_SL_FIN : S_SL_RD;
      S_SL_FIN:   state_d = out_free ? S_IDLE : S_SL_FIN;
      S_RESP:     state_d = out_free ? S_IDLE : S_RESP;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    jdx_d      = jdx_q;
    wr_d       = wr_q;
    first_d    = first_q;
    end_d      = end_q;
    found_d    = found_q;
    pend_d     = pend_q;
    val_d      = val_q;
    cand_d     = cand_q;
    pend_val_d = pend_val_q;
    status_d   = status_q;
    mem_we     = 1'b0;
    mem_waddr  = wr_q[AddrW-1:0];
    mem_wdata  = rdata_q;
    push       = 1'b0;
    push_data  = '{status: ST_DONE, item_value: '0, item_valid: 1'b0,
                   count: cnt7, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d    = in_data_i.value;
          first_d  = CntW'(first7);
          end_d    = CntW'(end_clip7);
          wr_d     = '0;
          found_d  = 1'b0;
          pend_d   = 1'b0;
          idx_d    = (in_data_i.cmd == CMD_SLICE) ? CntW'(first7) : '0;
          status_d = ST_DONE;
          if (in_data_i.cmd == CMD_INSERT && full) status_d = ST_FULL;
          else if (in_data_i.cmd == CMD_REMOVE && count_q == '0) status_d = ST_MISSING;
          else if (in_data_i.cmd == CMD_SLICE && slice_empty) status_d = ST_EMPTY;
        end
      end
      S_SCAN_CMP: begin
        if (eq) status_d = ST_DUP;
        else idx_d = idx_inc;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = count_q[AddrW-1:0];
        mem_wdata = val_q;
        count_d   = count_q + CntW'(1);
        status_d  = ST_DONE;
      end
      S_REM_CMP: begin
        // write-back trails the read index, so compaction stays in place
        if (eq) begin
          found_d = 1'b1;
        end else begin
          mem_we = 1'b1;
          wr_d   = wr_q + CntW'(1);
        end
        idx_d = idx_inc;
      end
      S_REM_FIN: begin
        count_d  = wr_q;
        status_d = found_q ? ST_DONE : ST_MISSING;
      end
      S_SL_CAND: begin
        cand_d = rdata_q;
        jdx_d  = first_q;
      end
      S_SL_JCMP: jdx_d = jdx_inc;
      S_SL_EMIT: begin
        // hold one element back so the final word can carry last
        if (!pend_q) begin
          pend_d     = 1'b1;
          pend_val_d = cand_q;
        end else if (out_free) begin
          push       = 1'b1;
          push_data  = '{status: ST_DONE, item_value: pend_val_q, item_valid: 1'b1,
                         count: cnt7, last: 1'b0};
          pend_val_d = cand_q;
        end
      end
      S_SL_NEXT: idx_d = idx_inc;
      S_SL_FIN: begin
        if (out_free) begin
          push   = 1'b1;
          pend_d = 1'b0;
          if (pend_q) begin
            push_data = '{status: ST_DONE, item_value: pend_val_q, item_valid: 1'b1,
                          count: cnt7, last: 1'b1};
          end else begin
            push_data = '{status: ST_EMPTY, item_value: '0, item_valid: 1'b0,
                          count: cnt7, last: 1'b1};
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{status: status_q, item_value: '0, item_valid: 1'b0,
                        count: cnt7, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (push) begin
      out_d       = push_data;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      allow_q     <= 1'b1;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        allow_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    jdx_q      <= jdx_d;
    wr_q       <= wr_d;
    first_q    <= first_d;
    end_q      <= end_d;
    found_q    <= found_d;
    val_q      <= val_d;
    cand_q     <= cand_d;
    pend_val_q <= pend_val_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Entries))
    else $error("fill count above capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result word overwritten before it was taken");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_WR |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the list by one");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("accepted a word without leaving idle");

endmodule

### tb/tb_bounded_list_insert_remove_slice.sv
// Testbench for bounded_list_insert_remove_slice: random and directed list traffic.
`timescale 1ns / 1ps

module tb_bounded_list_insert_remove_slice
  import blirs_pkg::*;
();

  localparam logic [1:0]  CmdUnused    = 2'd3;
  localparam int unsigned MaxSliceLen  = 32;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned MaxReported  = 10;

  // Mirror of the list; expected result words wait in list_q.
  class list_scoreboard;
    logic [31:0] held [Entries];
    int unsigned fill;
    bit          allow_dup;
    out_t        list_q [$];
    int unsigned words_in, words_out, errors;
    int unsigned n_full, n_dup, n_missing, n_empty, n_elems;

    function new();
      fill      = 0;
      allow_dup = 1'b1;
    endfunction

    function void note_input(in_t w);
      logic [31:0] picked [$];
      out_t        r;
      status_e     st;
      int unsigned stop, wr;
      bit          hit;
      words_in++;
      st = ST_DONE;
      r  = '0;
      if (w.cmd == CMD_SLICE) begin
        stop = (w.end_index > fill) ? fill : w.end_index;
        if (w.first_index < fill) begin
          for (int unsigned i = w.first_index; i < stop && picked.size() < MaxSliceLen; i++) begin
            hit = 1'b0;
            if (!allow_dup) foreach (picked[k]) if (picked[k] == held[i]) hit = 1'b1;
            if (!hit) picked.push_back(held[i]);
          end
        end
        r.count = 7'(fill);
        if (picked.size() == 0) begin
          n_empty++;
          r.status = ST_EMPTY;
          r.last   = 1'b1;
          list_q.push_back(r);
        end else begin
          foreach (picked[k]) begin
            r.status     = ST_DONE;
            r.item_value = picked[k];
            r.item_valid = 1'b1;
            r.last       = (k == picked.size() - 1);
            list_q.push_back(r);
            n_elems++;
          end
        end
        return;
      end
      case (w.cmd)
        CMD_INSERT: begin
          hit = 1'b0;
          for (int unsigned i = 0; i < fill; i++) if (held[i] == w.value) hit = 1'b1;
          if (fill >= Entries) begin
            st = ST_FULL;
            n_full++;
          end else if (!allow_dup && hit) begin
            st = ST_DUP;
            n_dup++;
          end else begin
            held[fill] = w.value;
            fill++;
          end
        end
        CMD_REMOVE: begin
          wr  = 0;
          hit = 1'b0;
          for (int unsigned rd = 0; rd < fill; rd++) begin
            if (held[rd] == w.value) begin
              hit = 1'b1;
            end else begin
              held[wr] = held[rd];
              wr++;
            end
          end
          fill = wr;
          if (!hit) begin
            st = ST_MISSING;
            n_missing++;
          end
        end
        default: ;
      endcase
      r.status = st;
      r.count  = 7'(fill);
      r.last   = 1'b1;
      list_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      words_out++;
      if (list_q.size() == 0) begin
        errors++;
        if (errors <= MaxReported)
          $display("ERROR: unexpected word status %0d value %h valid %0b count %0d last %0b",
                   got.status, got.item_value, got.item_valid, got.count, got.last);
        return;
      end
      want = list_q.pop_front();
      if (got.status !== want.status || got.item_value !== want.item_value ||
          got.item_valid !== want.item_valid || got.count !== want.count ||
          got.last !== want.last) begin
        errors++;
        if (errors <= MaxReported)
          $display("ERROR: word %0d exp/got status %0d/%0d value %h/%h valid %0b/%0b",
                   words_out, want.status, got.status, want.item_value, got.item_value,
                   want.item_valid, got.item_valid,
                   " count %0d/%0d last %0b/%0b",
                   want.count, got.count, want.last, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i, cfg_wdata_i;
  logic in_valid_i, in_ready_o;
  in_t  in_data_i;
  logic out_valid_o, out_ready_i;
  out_t out_data_o;
  bit   calm = 1'b0;

  list_scoreboard sb = new();

  bounded_list_insert_remove_slice dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Signals sampled right after the edge still hold their pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin
    #20_000_000;
    $display("bounded_list_insert_remove_slice test failed");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'(int'($urandom_range(0, 39)) - 20);
    endcase
  endfunction

  // Mostly well-formed commands: removes of held values, slices inside the list.
  function automatic in_t random_word(int unsigned ins_pct, int unsigned rem_pct);
    in_t         w;
    int unsigned pick;
    pick          = $urandom_range(0, 99);
    w.cmd         = CMD_SLICE;
    w.value       = pick_value();
    w.first_index = 6'($urandom);
    w.end_index   = 7'($urandom_range(0, 64));
    if (pick < ins_pct) begin
      w.cmd = CMD_INSERT;
    end else if (pick < ins_pct + rem_pct) begin
      w.cmd = CMD_REMOVE;
      if (sb.fill > 0 && $urandom_range(0, 3) != 0)
        w.value = sb.held[$urandom_range(0, sb.fill - 1)];
    end else if (pick < 97) begin
      if (sb.fill > 0 && $urandom_range(0, 7) != 0) begin
        w.first_index = 6'($urandom_range(0, sb.fill - 1));
        w.end_index   = 7'($urandom_range(w.first_index, 64));
      end
    end else begin
      w.cmd = CmdUnused;
    end
    return w;
  endfunction

  task automatic send_word(input in_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [31:0] value,
                       input logic [5:0] first, input logic [6:0] stop);
    in_t w;
    w.cmd         = cmd;
    w.value       = value;
    w.first_index = first;
    w.end_index   = stop;
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.list_q.size() != 0 || !in_ready_o) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_allow_dup(input logic allow);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= allow;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.allow_dup = allow;
  endtask

  task automatic run_phase(input logic allow, input int unsigned words,
                           input int unsigned ins_pct, input int unsigned rem_pct);
    set_allow_dup(allow);
    repeat (words) send_word(random_word(ins_pct, rem_pct));
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extremes, duplicates, clipped and out-of-range slices.
    issue(CMD_SLICE,  32'h0,         6'd0,  7'd64);
    issue(CMD_REMOVE, 32'h5,         6'd0,  7'd0);
    issue(CMD_INSERT, 32'h8000_0000, 6'd0,  7'd0);
    issue(CMD_INSERT, 32'h7fff_ffff, 6'd0,  7'd0);
    issue(CMD_INSERT, 32'h0,         6'd0,  7'd0);
    issue(CMD_INSERT, 32'hffff_ffff, 6'd0,  7'd0);
    issue(CMD_INSERT, 32'h7fff_ffff, 6'd0,  7'd0);
    issue(CMD_INSERT, 32'h7fff_ffff, 6'd0,  7'd0);
    issue(CMD_INSERT, 32'h0,         6'd0,  7'd0);
    issue(CMD_SLICE,  32'h0,         6'd0,  7'd64);
    issue(CMD_SLICE,  32'h0,         6'd63, 7'd0);
    issue(CMD_SLICE,  32'h0,         6'd2,  7'd2);
    issue(CMD_SLICE,  32'h0,         6'd3,  7'd1);
    issue(CmdUnused,  32'hffff_ffff, 6'd63, 7'd64);
    set_allow_dup(1'b0);
    issue(CMD_SLICE,  32'h0,         6'd1,  7'd64);
    issue(CMD_INSERT, 32'h0,         6'd0,  7'd0);
    issue(CMD_INSERT, 32'h8000_0000, 6'd0,  7'd0);
    issue(CMD_INSERT, 32'h1234_5678, 6'd0,  7'd0);
    issue(CMD_REMOVE, 32'h7fff_ffff, 6'd0,  7'd0);
    issue(CMD_REMOVE, 32'hffff_ffff, 6'd0,  7'd0);
    issue(CMD_REMOVE, 32'hffff_ffff, 6'd0,  7'd0);
    issue(CMD_SLICE,  32'h0,         6'd0,  7'd3);

    run_phase(1'b1, 80, 70, 10);
    run_phase(1'b0, 80, 35, 30);
    run_phase(1'b0, 60, 75, 5);
    run_phase(1'b1, 50, 15, 60);
    wait_idle();
    calm = 1'b1;
    run_phase(1'b1, 50, 40, 25);

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d input words: %0d full, %0d duplicate, %0d missing, %0d empty slice",
             sb.words_in, sb.n_full, sb.n_dup, sb.n_missing, sb.n_empty);
    $display("Checked %0d result words (%0d slice elements), %0d mismatches",
             sb.words_out, sb.n_elems, sb.errors);
    if (sb.errors == 0) begin
      $display("bounded_list_insert_remove_slice test passed");
    end else begin
      $display("bounded_list_insert_remove_slice test failed");
    end
    $finish;
  end

endmodule
